// ----- src/palu_pkg.sv -----
// ----------------------------------------------------------------------------
// palu_pkg: shared types and codes of the positional array list
// Operation and status codes, and the command word that is sent to every cell.
// ----------------------------------------------------------------------------
package palu_pkg;

	localparam int ENTRY_W = 32;
	localparam int POS_W   = 8;
	// cells per read group, ORed together in the first level of the read tree
	localparam int GROUP   = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_e;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef struct packed {
		logic               ins_en;
		logic               del_en;
		logic [POS_W-1:0]   idx;
		logic [ENTRY_W-1:0] value;
	} cell_cmd_t;

endpackage

// ----- src/palu_cell.sv -----
// ----------------------------------------------------------------------------
// palu_cell: one list slot
// Holds one entry and takes its left or right neighbor on insert or delete.
// ----------------------------------------------------------------------------
module palu_cell import palu_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [ENTRY_W-1:0] left,
	input  logic [ENTRY_W-1:0] right,
	output logic [ENTRY_W-1:0] entry,
	output logic [ENTRY_W-1:0] rd
);

	localparam logic [POS_W-1:0] ID = POS_W'(IDX);

	logic [ENTRY_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (ID == cmd.idx) begin
				entry_q <= cmd.value;
			end else if (ID > cmd.idx) begin
				entry_q <= left;
			end
		end else if (cmd.del_en) begin
			if (ID >= cmd.idx) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;
	// read term, or-reduced across the group
	assign rd = (ID == cmd.idx) ? entry_q : '0;

endmodule

// ----- src/positional_array_list_unit.sv -----
// ----------------------------------------------------------------------------
// positional_array_list_unit: fixed-capacity list with insert/delete by position
// Row of cells, one per slot, shifting together on insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries op, position (1-based) and value.
//   Output channel out_valid/out_ready carries status, value_out and count.
//   Every input beat gives exactly one output beat, in order.
// Pipeline: an accepted beat is held in stage 1; decode, shift and the first
//   OR level are registered into stage 2, and the second OR level into the
//   output register.
// Throughput: one beat per cycle while out_ready is high; the cell row shifts
//   all slots in the same cycle, and the addressed slot is read by a two-level
//   OR tree over two stages, so the next beat sees the updated list right away.
// Stall: while out_ready is low the result holds; the two inner stages fill
//   and in_ready drops once they are both occupied.
// Reset: arst_n clears the length and all valid flags; the entry storage is
//   not cleared, as slots beyond the length are never read.
// ----------------------------------------------------------------------------
module positional_array_list_unit import palu_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [ENTRY_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic signed [ENTRY_W-1:0] value_out,
	output logic [POS_W-1:0]          count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

	// stage 1: accepted beat
	logic                v_s1;
	op_e                 op_s1;
	logic [POS_W-1:0]    pos_s1;
	logic [ENTRY_W-1:0]  val_s1;
	// list length
	logic [CW-1:0]       used_q;
	// stage 2: decoded result and group read
	logic                v_s2;
	logic [1:0]          status_s2;
	logic [CW-1:0]       cnt_s2;
	logic                rdok_s2;
	logic [ENTRY_W-1:0]  grp_s2 [NG];
	// output register
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [ENTRY_W-1:0]  value_q;
	logic [CW-1:0]       cnt_q;

	logic s1_adv, s2_adv;
	logic [POS_W:0] pos9, cnt9;
	logic full, ins_ok, rd_ok;
	logic [1:0] status_d;
	logic [CW-1:0] used_d;
	cell_cmd_t cmd;
	logic [ENTRY_W-1:0] entry [CAPACITY];
	logic [ENTRY_W-1:0] rd [CAPACITY];
	logic [ENTRY_W-1:0] grp_d [NG];
	logic [ENTRY_W-1:0] rd_all;

	assign s2_adv   = v_s2 && (!out_valid_q || out_ready);
	assign s1_adv   = v_s1 && (!v_s2 || s2_adv);
	assign in_ready = !v_s1 || s1_adv;

	// decode against the current length
	always_comb begin
		pos9   = {1'b0, pos_s1};
		cnt9   = (POS_W + 1)'(used_q);
		full   = (cnt9 >= (POS_W + 1)'(CAPACITY));
		ins_ok = (op_s1 == OP_INSERT) && !full && (pos_s1 != '0) && (pos9 <= cnt9 + 1'b1);
		rd_ok  = ((op_s1 == OP_DELETE) || (op_s1 == OP_GET)) && (pos_s1 != '0)
			&& (pos9 <= cnt9);
		used_d = used_q;
		case (op_s1)
			OP_INSERT: begin
				status_d = full ? ST_FULL : (ins_ok ? ST_OK : ST_BADPOS);
				if (ins_ok) used_d = used_q + 1'b1;
			end
			OP_DELETE: begin
				status_d = rd_ok ? ST_OK : ST_BADPOS;
				if (rd_ok) used_d = used_q - 1'b1;
			end
			OP_GET: begin
				status_d = rd_ok ? ST_OK : ST_BADPOS;
			end
			OP_CLEAR: begin
				status_d = ST_OK;
				used_d   = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		cmd.ins_en = s1_adv && ins_ok;
		cmd.del_en = s1_adv && rd_ok && (op_s1 == OP_DELETE);
		cmd.idx    = pos_s1 - 1'b1;
		cmd.value  = val_s1;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ENTRY_W-1:0] left, right;
		if (i == 0) begin : g_first
			assign left = val_s1;
		end else begin : g_mid_l
			assign left = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = entry[i];
		end else begin : g_mid_r
			assign right = entry[i+1];
		end
		palu_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.entry (entry[i]),
			.rd    (rd[i])
		);
	end

	// first level of the read tree
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GROUP; j++) begin
				if (g * GROUP + j < CAPACITY) grp_d[g] = grp_d[g] | rd[g * GROUP + j];
			end
		end
	end

	// second level
	always_comb begin
		rd_all = '0;
		for (int g = 0; g < NG; g++) rd_all = rd_all | grp_s2[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			used_q      <= '0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (s1_adv) used_q <= used_d;
			if (s1_adv) v_s2 <= 1'b1;
			else if (s2_adv) v_s2 <= 1'b0;
			if (s2_adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= op_e'(op);
			pos_s1 <= position;
			val_s1 <= value;
		end
		if (s1_adv) begin
			status_s2 <= status_d;
			cnt_s2    <= used_d;
			rdok_s2   <= rd_ok;
			grp_s2    <= grp_d;
		end
		if (s2_adv) begin
			status_q <= status_s2;
			value_q  <= rdok_s2 ? rd_all : '0;
			cnt_q    <= cnt_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = value_q;
	assign count     = POS_W'(cnt_q);

endmodule

// ----- src/palu_checker.sv -----
// ----------------------------------------------------------------------------
// palu_checker: port-level checks of the positional array list
// Watches the result channel and its relation to the list capacity.
// ----------------------------------------------------------------------------
module palu_checker import palu_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                status,
	input logic signed [ENTRY_W-1:0] value_out,
	input logic [POS_W-1:0]          count
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out)
			&& $stable(count))
		else $error("result beat changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_BADPOS) && (32'(count) <= CAPACITY))
		else $error("bad status code or length above capacity");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (32'(count) == CAPACITY))
		else $error("full reported with list not at capacity");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (value_out != '0) |-> (status == ST_OK))
		else $error("nonzero value on a failed operation");

endmodule

bind positional_array_list_unit palu_checker #(.CAPACITY(CAPACITY)) u_palu_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the positional array list unit
// Drives insert, delete, get and clear beats through the valid/ready input,
// tracks the list contents in a local model and checks every output beat
// against it, with random idling on both sides and long output hold-offs.
// ----------------------------------------------------------------------------
module tb;
	import palu_pkg::*;

	localparam int LIST_CAP   = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;

	typedef struct packed {
		logic [1:0]         op;
		logic [POS_W-1:0]   pos;
		logic [ENTRY_W-1:0] val;
	} list_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ENTRY_W-1:0] value;
		logic [POS_W-1:0]   count;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_INSERT;
	logic [POS_W-1:0]   position = '0;
	logic signed [ENTRY_W-1:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [ENTRY_W-1:0] value_out;
	logic [POS_W-1:0]   count;

	list_cmd_t    cmd_q[$];
	list_result_t result_q[$];

	// local copy of the list
	logic [ENTRY_W-1:0] list_mem [LIST_CAP];
	int                 list_len = 0;
	// length as seen by the stimulus generator
	int                 gen_len = 0;

	int err_count = 0;
	int tx_gap = 0;
	int tx_quiet = 0;
	int rx_gap = 0;
	int rx_quiet = 0;
	int rx_hold = 0;
	int rx_cycles = 0;
	int stall_cycles = 0;

	positional_array_list_unit #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value_out (value_out),
		.count     (count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic list_result_t apply_list_op(logic [1:0] o, logic [POS_W-1:0] p,
			logic [ENTRY_W-1:0] v);
		list_result_t r;
		int k;
		int pi;
		r.status = ST_OK;
		r.value  = '0;
		pi = int'(p);
		case (op_e'(o))
			OP_INSERT: begin
				if (list_len >= LIST_CAP)
					r.status = ST_FULL;
				else if (pi < 1 || pi > list_len + 1)
					r.status = ST_BADPOS;
				else begin
					for (k = list_len; k >= pi; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[pi-1] = v;
					list_len++;
				end
			end
			OP_DELETE, OP_GET: begin
				if (list_len == 0 || pi < 1 || pi > list_len)
					r.status = ST_BADPOS;
				else begin
					r.value = list_mem[pi-1];
					if (op_e'(o) == OP_DELETE) begin
						for (k = pi; k < list_len; k++)
							list_mem[k-1] = list_mem[k];
						list_len--;
					end
				end
			end
			default: list_len = 0;
		endcase
		r.count = list_len[POS_W-1:0];
		return r;
	endfunction

	// idle length: mostly none or short, a few long, and quiet stretches with none
	function automatic int draw_gap(inout int quiet, input int idle_pct);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			quiet = $urandom_range(20, 50);
			return 0;
		end
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	// queue a command and follow the list length it leads to
	task automatic add_cmd(logic [1:0] o, int p, logic [ENTRY_W-1:0] v);
		list_cmd_t c;
		c.op  = o;
		c.pos = p[POS_W-1:0];
		c.val = v;
		cmd_q.push_back(c);
		case (op_e'(o))
			OP_INSERT: if (gen_len < LIST_CAP && p >= 1 && p <= gen_len + 1) gen_len++;
			OP_DELETE: if (gen_len > 0 && p >= 1 && p <= gen_len) gen_len--;
			OP_CLEAR:  gen_len = 0;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [ENTRY_W-1:0] got,
			logic [ENTRY_W-1:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic logic [ENTRY_W-1:0] pick_value();
		case ($urandom_range(0, 39))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		list_cmd_t nxt;
		logic launch;
		launch = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				result_q.push_back(apply_list_op(op, position, value));
				tx_gap = draw_gap(tx_quiet, 45);
				launch = (tx_gap == 0) && (cmd_q.size() > 0);
			end else if (!in_valid) begin
				if (tx_gap > 0)
					tx_gap--;
				else
					launch = cmd_q.size() > 0;
			end
			if (launch) begin
				nxt = cmd_q.pop_front();
				op       <= nxt.op;
				position <= nxt.pos;
				value    <= nxt.val;
			end
			if (launch)
				in_valid <= 1'b1;
			else if (in_valid && in_ready)
				in_valid <= 1'b0;
		end
	end

	// receiver readiness, with two long hold-offs to back the list up
	always @(posedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (arst_n) begin
			rx_cycles++;
			if (rx_cycles == 300 || rx_cycles == 1500)
				rx_hold = 120;
			if (rx_hold > 0) begin
				rx_hold--;
				rdy = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if (out_valid && out_ready) begin
				rx_gap = draw_gap(rx_quiet, 35);
				if (rx_gap > 0) begin
					rx_gap--;
					rdy = 1'b0;
				end
			end
			out_ready <= rdy;
		end
	end

	// monitor
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0)
				report_mismatch("beat with nothing pending, status", 32'(status), '0);
			else begin
				want = result_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (value_out !== want.value)
					report_mismatch("value_out", value_out, want.value);
				if (count !== want.count)
					report_mismatch("count", 32'(count), 32'(want.count));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int r;
		int p;
		logic [1:0] o;
		bit filling;

		// empty list errors
		add_cmd(OP_GET, 1, 32'h1234_5678);
		add_cmd(OP_DELETE, 0, 32'hffff_ffff);
		add_cmd(OP_INSERT, 0, 32'h5555_5555);
		add_cmd(OP_INSERT, 2, 32'haaaa_aaaa);
		// value extremes, front and tail inserts
		add_cmd(OP_INSERT, 1, 32'h7fff_ffff);
		add_cmd(OP_INSERT, 1, 32'h8000_0000);
		add_cmd(OP_INSERT, 3, 32'hffff_ffff);
		add_cmd(OP_GET, 0, 32'h0);
		add_cmd(OP_GET, 4, 32'h0);
		add_cmd(OP_GET, 2, 32'h0);
		// fill up to capacity
		while (gen_len < LIST_CAP)
			add_cmd(OP_INSERT, $urandom_range(1, gen_len + 1), $urandom);
		// full is reported ahead of a bad position
		add_cmd(OP_INSERT, 0, 32'h0);
		add_cmd(OP_INSERT, 255, 32'h0);
		add_cmd(OP_GET, LIST_CAP, 32'h0);
		add_cmd(OP_DELETE, LIST_CAP, 32'h0);
		add_cmd(OP_GET, LIST_CAP, 32'h0);
		add_cmd(OP_CLEAR, 255, 32'hffff_ffff);
		add_cmd(OP_GET, 1, 32'h0);

		filling = 1'b1;
		for (i = 0; i < 650; i++) begin
			if (gen_len == LIST_CAP)
				filling = 1'b0;
			else if (gen_len == 0)
				filling = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 3)
				o = OP_CLEAR;
			else if (filling)
				o = (r < 63) ? OP_INSERT : (r < 81) ? OP_DELETE : OP_GET;
			else
				o = (r < 23) ? OP_INSERT : (r < 63) ? OP_DELETE : OP_GET;
			if ($urandom_range(0, 99) < 12)
				p = $urandom_range(0, 255);
			else if (op_e'(o) == OP_INSERT)
				p = $urandom_range(1, (gen_len < LIST_CAP) ? gen_len + 1 : LIST_CAP);
			else if (gen_len > 0)
				p = $urandom_range(1, gen_len);
			else
				p = $urandom_range(0, 255);
			add_cmd(o, p, pick_value());
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver's queue pop and in_valid agree
		while (cmd_q.size() > 0 || in_valid || result_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
src/palu_pkg.sv
src/palu_cell.sv
src/positional_array_list_unit.sv
src/palu_checker.sv
sim/tb.sv
